[hw/rtl/sqwt_pkg.sv]
package sqwt_pkg;

    // Width of the sample field and of the estimate, minimum, maximum and count fields on the channels.
    localparam int FIELD_W = 32;
    // Width of the sample and below counters.
    localparam int CNT_W = 32;
    // Quantile fraction: 17 bits, where 1 << Q_FRAC stands for 1.0.
    localparam int Q_W = 17;
    localparam int Q_FRAC = 16;
    localparam int PROD_W = Q_W + CNT_W;
    // Track count register width and the number of tracks the result carries.
    localparam int TC_W = 3;
    localparam int OUT_TRACKS = 4;
    localparam int OUT_IDX_W = 2;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTILE_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTILE_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTILE_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTILE_3 = 3'd4;

endpackage

[hw/rtl/sqwt_if.sv]
// Sample request channel.
interface sqwt_sample_if;
    logic                          valid;
    logic                          ready;
    logic [sqwt_pkg::FIELD_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

// Result request channel.
interface sqwt_result_if;
    logic                              valid;
    logic                              ready;
    logic [sqwt_pkg::FIELD_W-1:0]      estimate_0;
    logic [sqwt_pkg::FIELD_W-1:0]      estimate_1;
    logic [sqwt_pkg::FIELD_W-1:0]      estimate_2;
    logic [sqwt_pkg::FIELD_W-1:0]      estimate_3;
    logic [sqwt_pkg::FIELD_W-1:0]      smallest_seen;
    logic [sqwt_pkg::FIELD_W-1:0]      largest_seen;
    logic [sqwt_pkg::FIELD_W-1:0]      samples_seen;
    logic [sqwt_pkg::OUT_TRACKS-1:0]   tracks_ready;

    modport source (output valid, output estimate_0, output estimate_1, output estimate_2,
                    output estimate_3, output smallest_seen, output largest_seen,
                    output samples_seen, output tracks_ready, input ready);
    modport sink (input valid, input estimate_0, input estimate_1, input estimate_2,
                  input estimate_3, input smallest_seen, input largest_seen,
                  input samples_seen, input tracks_ready, output ready);
endinterface

[hw/rtl/sqwt_track_unit.sv]
// Window memory and the per-track read, insert and write-back datapath.
// The filled part of each track row is kept sorted, so seeding needs no extra sort.
module sqwt_track_unit #(
    parameter int TRACKS = 4,
    parameter int HALF_WINDOW = 2,
    parameter int SAMPLE_BITS = 32,
    localparam int IDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 issue_en,
    input  logic [IDX_W-1:0]                     issue_idx,
    input  logic [sqwt_pkg::Q_W-1:0]             issue_quantile,
    input  logic [sqwt_pkg::CNT_W-1:0]           total,
    input  logic [SAMPLE_BITS-1:0]               sample,
    output logic [TRACKS-1:0][SAMPLE_BITS-1:0]   estimates,
    output logic [TRACKS-1:0]                    seeded
);

    localparam int WIN = 2 * HALF_WINDOW + 1;
    localparam int FW = $clog2(WIN + 2);
    localparam int CW = sqwt_pkg::CNT_W;
    localparam int PW = sqwt_pkg::PROD_W;
    localparam int TW = PW - sqwt_pkg::Q_FRAC;
    localparam logic [FW-1:0] FILL_FULL = FW'(WIN);
    localparam logic [FW-1:0] FILL_SEEDED = FW'(WIN + 1);

    typedef logic [WIN-1:0][SAMPLE_BITS-1:0] row_t;

    row_t                    win_mem [TRACKS];
    row_t                    rd_row_reg;
    logic                    upd_vld_reg;
    logic [IDX_W-1:0]        upd_idx_reg;
    logic [PW-1:0]           prod_reg;

    logic [FW-1:0]           fill_reg [TRACKS];
    logic [FW-1:0]           fill_next [TRACKS];
    logic [CW-1:0]           below_reg [TRACKS];
    logic [CW-1:0]           below_next [TRACKS];
    logic [SAMPLE_BITS-1:0]  est_reg [TRACKS];
    logic [SAMPLE_BITS-1:0]  est_next [TRACKS];

    logic [FW-1:0]           fill_cur;
    logic                    warm;
    logic                    seeding;
    logic [SAMPLE_BITS-1:0]  est_cur;
    logic [CW-1:0]           below_cur;
    logic [CW-1:0]           below_new;
    logic                    count_up;
    logic [TW-1:0]           target;
    logic                    drop_large;
    logic [WIN-1:0]          lt_row;
    logic [WIN-2:0][SAMPLE_BITS-1:0] base;
    logic [WIN-2:0]          lt_base;
    row_t                    new_row;

    // Memory: one row per track, read registered, written by the update stage.
    always_ff @(posedge clk)
    begin
        if (upd_vld_reg)
        begin
            win_mem[upd_idx_reg] <= new_row;
        end
        if (issue_en)
        begin
            rd_row_reg <= win_mem[issue_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_en)
        begin
            upd_idx_reg <= issue_idx;
            prod_reg <= PW'(issue_quantile) * PW'(total);
        end
    end

    always_comb
    begin
        fill_cur = fill_reg[upd_idx_reg];
        warm = fill_cur < FILL_FULL;
        seeding = fill_cur == FILL_FULL;
        est_cur = seeding ? rd_row_reg[HALF_WINDOW] : est_reg[upd_idx_reg];
        below_cur = seeding ? CW'(HALF_WINDOW) : below_reg[upd_idx_reg];
        count_up = (sample < est_cur) && (below_cur != '1);
        below_new = below_cur + CW'(count_up);
        target = prod_reg[PW-1:sqwt_pkg::Q_FRAC];
        // The comparison against the target is taken on the old count in
        // both forms, so it runs beside the sample compare.
        drop_large = count_up ? ({1'b0, below_cur} >= target)
                              : ({1'b0, below_cur} > target);

        for (int k = 0; k < WIN; k++)
        begin
            lt_row[k] = rd_row_reg[k] < sample;
        end

        for (int k = 0; k < WIN - 1; k++)
        begin
            if (warm)
            begin
                base[k] = rd_row_reg[k];
                lt_base[k] = lt_row[k] && (FW'(k) < fill_cur);
            end
            else if (drop_large)
            begin
                base[k] = rd_row_reg[k];
                lt_base[k] = lt_row[k];
            end
            else
            begin
                base[k] = rd_row_reg[k + 1];
                lt_base[k] = lt_row[k + 1];
            end
        end

        // Sorted insert: entries below the sample stay, the sample takes the
        // first place where the base is not below it, the rest move up.
        new_row[0] = lt_base[0] ? base[0] : sample;
        for (int k = 1; k < WIN - 1; k++)
        begin
            new_row[k] = lt_base[k] ? base[k] : (lt_base[k - 1] ? sample : base[k - 1]);
        end
        new_row[WIN - 1] = lt_base[WIN - 2] ? sample : base[WIN - 2];

        for (int t = 0; t < TRACKS; t++)
        begin
            fill_next[t] = fill_reg[t];
            below_next[t] = below_reg[t];
            est_next[t] = est_reg[t];
        end
        if (upd_vld_reg)
        begin
            if (warm)
            begin
                fill_next[upd_idx_reg] = fill_cur + FW'(1);
            end
            else
            begin
                fill_next[upd_idx_reg] = FILL_SEEDED;
                below_next[upd_idx_reg] = below_new;
                est_next[upd_idx_reg] = new_row[HALF_WINDOW];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_vld_reg <= 1'b0;
            for (int t = 0; t < TRACKS; t++)
            begin
                fill_reg[t] <= '0;
                below_reg[t] <= '0;
                est_reg[t] <= '0;
            end
        end
        else
        begin
            upd_vld_reg <= issue_en;
            for (int t = 0; t < TRACKS; t++)
            begin
                fill_reg[t] <= fill_next[t];
                below_reg[t] <= below_next[t];
                est_reg[t] <= est_next[t];
            end
        end
    end

    always_comb
    begin
        for (int t = 0; t < TRACKS; t++)
        begin
            estimates[t] = est_reg[t];
            seeded[t] = fill_reg[t] == FILL_SEEDED;
        end
    end

    // A row is never read in the same cycle as it is written back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (issue_en && upd_vld_reg) |-> (issue_idx != upd_idx_reg))
        else $error("window row read while its update is in flight");

    // The seeding update marks its track as ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        (upd_vld_reg && seeding) |=> seeded[$past(upd_idx_reg)])
        else $error("track not marked ready after seeding");

    // A seeded row stays sorted, so its median lies between its ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        (upd_vld_reg && !warm) |-> ((new_row[0] <= new_row[HALF_WINDOW])
                                    && (new_row[HALF_WINDOW] <= new_row[WIN - 1])))
        else $error("window row lost its order");

endmodule

[hw/rtl/streaming_quantile_window_tracker.sv]
// A sample request is taken in IDLE; RUN then issues one window memory read per
// active track, each followed by a sorted-insert write-back that overlaps the
// next track's read; FINISH loads the result into the output register. A new
// sample is taken only after the result has been loaded.
// Reset (rst_n, asynchronous, active low) clears counters, maximum, estimates and
// track fill state and sets the minimum to all ones; the window memory itself is not cleared.
module streaming_quantile_window_tracker #(
    parameter int TRACKS = 4,
    parameter int HALF_WINDOW = 2,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sqwt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sqwt_pkg::Q_W-1:0]          cfg_data,
    sqwt_sample_if.sink                       samples,
    sqwt_result_if.source                     results
);

    localparam int IDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int FW = sqwt_pkg::FIELD_W;
    localparam int CW = sqwt_pkg::CNT_W;
    localparam int TCW = sqwt_pkg::TC_W;
    localparam int OT = sqwt_pkg::OUT_TRACKS;
    localparam logic [TCW-1:0] TRACKS_MAX = TCW'(TRACKS);

    // One-hot sequencer: IDLE takes a sample request, RUN walks the active
    // tracks through the window memory, FINISH hands the result over.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RUN    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;

    // Configuration registers.
    logic [TCW-1:0]              track_count_reg;
    logic [sqwt_pkg::Q_W-1:0]    quantile_reg [OT];

    // Global statistics and per-request control.
    logic [CW-1:0]               total_reg;
    logic [CW-1:0]               total_next;
    logic [SAMPLE_BITS-1:0]      min_reg;
    logic [SAMPLE_BITS-1:0]      max_reg;
    logic [SAMPLE_BITS-1:0]      sample_reg;
    logic [SAMPLE_BITS-1:0]      sample_in;
    logic [TCW-1:0]              active_reg;
    logic [TCW-1:0]              active_now;
    logic [TCW-1:0]              iss_cnt_reg;
    logic [TCW-1:0]              iss_cnt_next;

    logic                        accept;
    logic                        issue_en;
    logic                        load_result;

    logic [TRACKS-1:0][SAMPLE_BITS-1:0] estimates;
    logic [TRACKS-1:0]                  seeded;
    logic [OT-1:0][FW-1:0]              est_pad;
    logic [OT-1:0]                      ready_pad;

    // Output register: the result waits here while the next sample is taken.
    logic                        res_vld_reg;
    logic [OT-1:0][FW-1:0]       res_est_reg;
    logic [FW-1:0]               res_min_reg;
    logic [FW-1:0]               res_max_reg;
    logic [FW-1:0]               res_total_reg;
    logic [OT-1:0]               res_ready_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_count_reg <= TCW'(1);
            for (int i = 0; i < OT; i++)
            begin
                quantile_reg[i] <= sqwt_pkg::Q_W'(32768);
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sqwt_pkg::REG_TRACK_COUNT: track_count_reg <= cfg_data[TCW-1:0];
                sqwt_pkg::REG_QUANTILE_0:  quantile_reg[0] <= cfg_data;
                sqwt_pkg::REG_QUANTILE_1:  quantile_reg[1] <= cfg_data;
                sqwt_pkg::REG_QUANTILE_2:  quantile_reg[2] <= cfg_data;
                sqwt_pkg::REG_QUANTILE_3:  quantile_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign samples.ready = (state_reg == ST_IDLE);
    assign accept = samples.valid && samples.ready;
    assign sample_in = SAMPLE_BITS'(samples.sample);
    // A track count above the number of built tracks uses all of them.
    assign active_now = (track_count_reg > TRACKS_MAX) ? TRACKS_MAX : track_count_reg;
    assign issue_en = (state_reg == ST_RUN) && (iss_cnt_reg < active_reg);
    assign load_result = (state_reg == ST_FINISH) && (!res_vld_reg || results.ready);
    // The sample counter saturates rather than wrapping.
    assign total_next = (total_reg == '1) ? total_reg : total_reg + CW'(1);

    always_comb
    begin
        state_next = state_reg;
        iss_cnt_next = iss_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    iss_cnt_next = '0;
                    state_next = (active_now == '0) ? ST_FINISH : ST_RUN;
                end
            end
            ST_RUN:
            begin
                // Once the last track has been issued, its write-back
                // completes in this cycle.
                if (issue_en)
                begin
                    iss_cnt_next = iss_cnt_reg + TCW'(1);
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (load_result)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            iss_cnt_reg <= '0;
            active_reg <= '0;
            total_reg <= '0;
            min_reg <= '1;
            max_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iss_cnt_reg <= iss_cnt_next;
            if (accept)
            begin
                active_reg <= active_now;
                total_reg <= total_next;
                if (sample_in < min_reg)
                begin
                    min_reg <= sample_in;
                end
                if (sample_in > max_reg)
                begin
                    max_reg <= sample_in;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample_in;
        end
    end

    sqwt_track_unit #(
        .TRACKS      (TRACKS),
        .HALF_WINDOW (HALF_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_track (
        .clk            (clk),
        .rst_n          (rst_n),
        .issue_en       (issue_en),
        .issue_idx      (iss_cnt_reg[IDX_W-1:0]),
        .issue_quantile (quantile_reg[iss_cnt_reg[sqwt_pkg::OUT_IDX_W-1:0]]),
        .total          (total_reg),
        .sample         (sample_reg),
        .estimates      (estimates),
        .seeded         (seeded)
    );

    // Result slots for tracks that are not built read as zero.
    for (genvar g = 0; g < OT; g++)
    begin : g_pad
        if (g < TRACKS)
        begin : g_built
            assign est_pad[g] = FW'(estimates[g]);
            assign ready_pad[g] = seeded[g];
        end
        else
        begin : g_absent
            assign est_pad[g] = '0;
            assign ready_pad[g] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (load_result)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            res_est_reg <= est_pad;
            res_min_reg <= FW'(min_reg);
            res_max_reg <= FW'(max_reg);
            res_total_reg <= total_reg;
            res_ready_reg <= ready_pad;
        end
    end

    assign results.valid = res_vld_reg;
    assign results.estimate_0 = res_est_reg[0];
    assign results.estimate_1 = res_est_reg[1];
    assign results.estimate_2 = res_est_reg[2];
    assign results.estimate_3 = res_est_reg[3];
    assign results.smallest_seen = res_min_reg;
    assign results.largest_seen = res_max_reg;
    assign results.samples_seen = res_total_reg;
    assign results.tracks_ready = res_ready_reg;

    // When the issue count runs out, the sequencer moves on to hand over.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && !issue_en) |=> (state_reg == ST_FINISH))
        else $error("sequencer stayed in RUN after the last track");

    // Once any sample has arrived, the minimum cannot exceed the maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg != '0) |-> (min_reg <= max_reg))
        else $error("minimum above maximum");

    // Each accepted sample moves the counter up or leaves it saturated.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ((total_reg != '0) && (total_reg >= $past(total_reg))))
        else $error("sample counter went backwards");

endmodule
